>>> hw/rtl/biu_pkg.sv
// Shared types and constants for the box intersection-over-union pipeline.
`timescale 1ns / 1ps
`default_nettype none

package biu_pkg;

  // Result field widths
  localparam int RATIO_BITS = 16;
  localparam int OUT_BITS   = RATIO_BITS + 1;

  // Result kind carried down the pipeline with each transaction
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_DIV   = 2'd0;  // ratio comes from the divider
  localparam kind_t KIND_ONE   = 2'd1;  // intersection covers the union, ratio is 1.0
  localparam kind_t KIND_ZERO  = 2'd2;  // inverted intersection, ratio is 0
  localparam kind_t KIND_DEGEN = 2'd3;  // union not positive, ratio is 0 and flag set

  // Per-stage control: valid bit and result kind
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } biu_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/biu_geom.sv
// Geometry front end: intersection, areas, union and result classification.
`timescale 1ns / 1ps
`default_nettype none

module biu_geom #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      ce,
  input  wire logic                      in_valid,
  input  wire logic [8*COORD_BITS-1:0]   in_edges,
  output biu_pkg::biu_ctl_t              ctl,
  output logic [2*COORD_BITS+1:0]        num,
  output logic [2*COORD_BITS+1:0]        den
);

  localparam int C = COORD_BITS;
  localparam int D = C + 1;          // edge difference, signed
  localparam int P = 2 * C + 2;      // area product, signed
  localparam int U = 2 * C + 3;      // union, signed
  localparam int R = 2 * C + 2;      // divider operand width

  // Unpack edges, a_left in the lowest bits
  logic signed [C-1:0] al, at, ar, ab, bl, bt, br, bb;
  assign al = $signed(in_edges[0*C +: C]);
  assign at = $signed(in_edges[1*C +: C]);
  assign ar = $signed(in_edges[2*C +: C]);
  assign ab = $signed(in_edges[3*C +: C]);
  assign bl = $signed(in_edges[4*C +: C]);
  assign bt = $signed(in_edges[5*C +: C]);
  assign br = $signed(in_edges[6*C +: C]);
  assign bb = $signed(in_edges[7*C +: C]);

  // Stage 1: intersection edges and box extents
  logic                s1_valid;
  logic signed [C-1:0] s1_il, s1_it, s1_ir, s1_ib;
  logic signed [D-1:0] s1_adw, s1_adh, s1_bdw, s1_bdh;

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_il  <= (al > bl) ? al : bl;
      s1_it  <= (at > bt) ? at : bt;
      s1_ir  <= (ar < br) ? ar : br;
      s1_ib  <= (ab < bb) ? ab : bb;
      s1_adw <= $signed({ar[C-1], ar}) - $signed({al[C-1], al});
      s1_adh <= $signed({ab[C-1], ab}) - $signed({at[C-1], at});
      s1_bdw <= $signed({br[C-1], br}) - $signed({bl[C-1], bl});
      s1_bdh <= $signed({bb[C-1], bb}) - $signed({bt[C-1], bt});
    end
  end

  // Stage 2: inversion test, intersection extents, box areas
  logic                s2_valid;
  logic                s2_inv;
  logic [C-1:0]        s2_iw, s2_ih;
  logic signed [P-1:0] s2_area_a, s2_area_b;
  logic [D-1:0]        iw_next, ih_next;
  logic signed [P-1:0] area_a_next, area_b_next;

  assign iw_next = {s1_ir[C-1], s1_ir} - {s1_il[C-1], s1_il};
  assign ih_next = {s1_ib[C-1], s1_ib} - {s1_it[C-1], s1_it};
  assign area_a_next = $signed({{(P-D){s1_adw[D-1]}}, s1_adw})
                     * $signed({{(P-D){s1_adh[D-1]}}, s1_adh});
  assign area_b_next = $signed({{(P-D){s1_bdw[D-1]}}, s1_bdw})
                     * $signed({{(P-D){s1_bdh[D-1]}}, s1_bdh});

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_inv    <= (s1_it > s1_ib) || (s1_il > s1_ir);
      s2_iw     <= iw_next[C-1:0];
      s2_ih     <= ih_next[C-1:0];
      s2_area_a <= area_a_next;
      s2_area_b <= area_b_next;
    end
  end

  // Stage 3: intersection area, sum of box areas
  logic                s3_valid;
  logic                s3_inv;
  logic [2*C-1:0]      s3_inter;
  logic signed [U-1:0] s3_sum;

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_inv   <= s2_inv;
      s3_inter <= {{C{1'b0}}, s2_iw} * {{C{1'b0}}, s2_ih};
      s3_sum   <= $signed({s2_area_a[P-1], s2_area_a}) + $signed({s2_area_b[P-1], s2_area_b});
    end
  end

  // Stage 4: union
  logic                s4_valid;
  logic                s4_inv;
  logic [2*C-1:0]      s4_inter;
  logic signed [U-1:0] s4_uni;

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_inv   <= s3_inv;
      s4_inter <= s3_inter;
      s4_uni   <= s3_sum - $signed({3'b000, s3_inter});
    end
  end

  // Stage 5: classify and hand operands to the divider
  biu_pkg::kind_t kind_next;
  logic           uni_pos;
  logic           inter_ge;
  logic           s5_valid;
  biu_pkg::kind_t s5_kind;

  assign uni_pos  = !s4_uni[U-1] && (s4_uni != '0);
  assign inter_ge = $signed({3'b000, s4_inter}) >= s4_uni;

  always_comb begin
    if (s4_inv) begin
      kind_next = biu_pkg::KIND_ZERO;
    end else if (!uni_pos) begin
      kind_next = biu_pkg::KIND_DEGEN;
    end else if (inter_ge) begin
      kind_next = biu_pkg::KIND_ONE;
    end else begin
      kind_next = biu_pkg::KIND_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s5_kind <= kind_next;
      num     <= {2'b00, s4_inter};
      den     <= s4_uni[R-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (ce) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  assign ctl = '{valid: s5_valid, kind: s5_kind};

endmodule

`default_nettype wire

>>> hw/rtl/biu_frac_div.sv
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module biu_frac_div #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       ce,
  input  wire biu_pkg::biu_ctl_t          in_ctl,
  input  wire logic [2*COORD_BITS+1:0]    in_num,
  input  wire logic [2*COORD_BITS+1:0]    in_den,
  output biu_pkg::biu_ctl_t               out_ctl,
  output logic [FRAC_BITS-1:0]            out_quot
);

  localparam int R = 2 * COORD_BITS + 2;
  localparam int F = FRAC_BITS;

  logic              st_valid [0:F];
  biu_pkg::kind_t    st_kind  [0:F];
  logic [R-1:0]      st_rem   [0:F];
  logic [R-1:0]      st_den   [0:F];
  logic [F-1:0]      st_q     [0:F];

  // Stage 0 is the divider input
  assign st_valid[0] = in_ctl.valid;
  assign st_kind[0]  = in_ctl.kind;
  assign st_rem[0]   = in_num;
  assign st_den[0]   = in_den;
  assign st_q[0]     = '0;

  // One shift, trial subtract and select per stage
  for (genvar g = 0; g < F; g++) begin : g_step
    logic [R:0]   shifted;
    logic [R+1:0] trial;
    logic         ge;

    assign shifted = {st_rem[g], 1'b0};
    assign trial   = {1'b0, shifted} - {2'b00, st_den[g]};
    assign ge      = !trial[R+1];

    always_ff @(posedge clk) begin
      if (ce) begin
        st_kind[g+1] <= st_kind[g];
        st_rem[g+1]  <= ge ? trial[R-1:0] : shifted[R-1:0];
        st_den[g+1]  <= st_den[g];
        st_q[g+1]    <= {st_q[g][F-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[g+1] <= 1'b0;
      end else if (ce) begin
        st_valid[g+1] <= st_valid[g];
      end
    end
  end

  assign out_ctl  = '{valid: st_valid[F], kind: st_kind[F]};
  assign out_quot = st_q[F];

`ifndef NO_ASSERTIONS
  // Dividend must start below the divisor
  a_div_in_range: assert property (@(posedge clk) disable iff (rst)
    (st_valid[0] && st_kind[0] == biu_pkg::KIND_DIV) |-> (st_rem[0] < st_den[0]))
    else $error("divider input remainder not below divisor");

  // Remainder ends below the divisor after the last step
  a_div_out_range: assert property (@(posedge clk) disable iff (rst)
    (st_valid[F] && st_kind[F] == biu_pkg::KIND_DIV) |-> (st_rem[F] < st_den[F]))
    else $error("divider final remainder not below divisor");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/biu_out_buf.sv
// Two-entry output buffer that decouples the pipeline from the output stall.
`timescale 1ns / 1ps
`default_nettype none

module biu_out_buf #(
  parameter int WIDTH = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             pop;

  assign pop   = out_valid && out_ready;
  assign ready = !skid_valid;

  // Main output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
      if (push) begin
        out_data <= push_data;
      end
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= push;
        if (push) begin
          skid_data <= push_data;
        end
      end else begin
        out_valid <= push;
        if (push) begin
          out_data <= push_data;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  // Skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/box_iou_unit.sv
// Top level of the box intersection-over-union unit.
`timescale 1ns / 1ps
`default_nettype none

// Computes intersection over union of two axis-aligned boxes given as signed
// edges. One box pair is accepted every clock cycle while s_axis_tready is high;
// a result passes through five geometry stages, one divider stage per fraction
// bit and one output register, the first stage loading at the accepting edge.
// The ratio is an unsigned fraction with FRAC_BITS fractional bits, truncated,
// masked to 16 bits; 1 << FRAC_BITS means 1.0 and overlap at or above the union
// saturates there. An inverted intersection gives 0; a union of zero or less
// gives 0 with tuser set. A held output lets one more result into the skid
// entry before s_axis_tready drops, so no result is lost on a stall.
module box_iou_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // tdata: a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [8*COORD_BITS-1:0]     s_axis_tdata,
  // tdata: overlap_ratio
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [biu_pkg::RATIO_BITS-1:0]   m_axis_tdata,
  // tuser: degenerate
  output logic                             m_axis_tuser
);

  localparam int R  = 2 * COORD_BITS + 2;
  localparam int RB = biu_pkg::RATIO_BITS;

  logic              ce;
  logic              in_valid;
  biu_pkg::biu_ctl_t geom_ctl;
  logic [R-1:0]      geom_num;
  logic [R-1:0]      geom_den;
  biu_pkg::biu_ctl_t div_ctl;
  logic [FRAC_BITS-1:0] div_quot;

  assign s_axis_tready = ce;
  assign in_valid      = s_axis_tvalid && ce;

  biu_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (in_valid),
    .in_edges (s_axis_tdata),
    .ctl      (geom_ctl),
    .num      (geom_num),
    .den      (geom_den)
  );

  biu_frac_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_ctl   (geom_ctl),
    .in_num   (geom_num),
    .in_den   (geom_den),
    .out_ctl  (div_ctl),
    .out_quot (div_quot)
  );

  // Final ratio select by result kind
  logic [FRAC_BITS:0]      ratio_full;
  logic [RB+FRAC_BITS:0]   ratio_wide;
  logic                    degen;

  always_comb begin
    ratio_full = '0;
    degen      = 1'b0;
    case (div_ctl.kind)
      biu_pkg::KIND_DIV:   ratio_full = {1'b0, div_quot};
      biu_pkg::KIND_ONE:   ratio_full = {1'b1, {FRAC_BITS{1'b0}}};
      biu_pkg::KIND_ZERO:  ratio_full = '0;
      biu_pkg::KIND_DEGEN: degen = 1'b1;
      default:             ratio_full = '0;
    endcase
  end

  assign ratio_wide = {{RB{1'b0}}, ratio_full};

  // Output buffer
  logic [biu_pkg::OUT_BITS-1:0] out_data;

  biu_out_buf #(
    .WIDTH (biu_pkg::OUT_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (div_ctl.valid && ce),
    .push_data ({degen, ratio_wide[RB-1:0]}),
    .ready     (ce),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = out_data[RB-1:0];
  assign m_axis_tuser = out_data[RB];

`ifndef NO_ASSERTIONS
  // Input side only stalls while a result is held at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");
`endif

endmodule

`default_nettype wire
